/* rtl/core/mbc_pkg.sv */
`timescale 1ns / 1ps
package mbc_pkg;

   localparam int FIX_W     = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int COORD_W   = 10;
   localparam int STEP_W    = 31;
   localparam int COUNT_W   = 16;
   localparam int CHAN_W    = 8;
   localparam int SEG_W     = 3;
   localparam int PAL_SIZE  = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_RE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IM      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_RE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_IM        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd4;

   localparam logic [SEG_W-1:0] SEG_LAST = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [FIX_W-1:0] fix_type;
   typedef logic [CHAN_W-1:0] chan_type;

   typedef struct packed {
      fix_type cr;
      fix_type ci;
   } point_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               in_set;
   } escape_type;

   // blue, green, yellow, red, black, black
   localparam chan_type PAL_RED   [PAL_SIZE] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
   localparam chan_type PAL_GREEN [PAL_SIZE] = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
   localparam chan_type PAL_BLUE  [PAL_SIZE] = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};

   localparam logic signed [63:0] FIX_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] FIX_MIN = 64'shFFFF_FFFF_8000_0000;

   function automatic fix_type sat_fix(input logic signed [63:0] v);
      if (v > FIX_MAX) begin
         return {1'b0, {(FIX_W-1){1'b1}}};
      end else if (v < FIX_MIN) begin
         return {1'b1, {(FIX_W-1){1'b0}}};
      end else begin
         return v[FIX_W-1:0];
      end
   endfunction

   // palette steps are full scale: quot = floor(255*r/q); frac_nz rounds a fall up
   function automatic chan_type mix_chan(input chan_type a, input chan_type b,
                                         input chan_type quot, input logic frac_nz);
      if (b == a) begin
         return a;
      end else if (b > a) begin
         return a + quot;
      end else begin
         return a - quot - {{(CHAN_W-1){1'b0}}, frac_nz};
      end
   endfunction

endpackage

/* rtl/core/mbc_front.sv */
`timescale 1ns / 1ps
module mbc_front import mbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [COORD_W-1:0] req_col,
   input  logic [COORD_W-1:0] req_row,
   input  fix_type            origin_re,
   input  fix_type            origin_im,
   input  logic [STEP_W-1:0]  step_re,
   input  logic [STEP_W-1:0]  step_im,
   output logic               push_valid,
   input  logic               push_ready,
   output point_type          push_data
);

   localparam int PROD_W = COORD_W + STEP_W;

   logic              s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0] re_prod_ff, re_prod_in;
   logic [PROD_W-1:0] im_prod_ff, im_prod_in;
   logic              advance;
   logic signed [63:0] re_sum, im_sum;

   assign advance   = !s1_valid_ff || push_ready;
   assign req_stall = !advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      re_prod_in  = re_prod_ff;
      im_prod_in  = im_prod_ff;
      if (advance) begin
         s1_valid_in = req_valid;
         re_prod_in  = PROD_W'(req_col) * PROD_W'(step_re);
         im_prod_in  = PROD_W'(req_row) * PROD_W'(step_im);
      end
   end

   assign re_sum = 64'(origin_re) + 64'(re_prod_ff);
   assign im_sum = 64'(origin_im) - 64'(im_prod_ff);

   assign push_valid   = s1_valid_ff;
   assign push_data.cr = sat_fix(re_sum);
   assign push_data.ci = sat_fix(im_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      re_prod_ff <= re_prod_in;
      im_prod_ff <= im_prod_in;
   end

endmodule

/* rtl/core/mbc_queue.sv */
`timescale 1ns / 1ps
module mbc_queue import mbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  point_type push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output point_type pop_data
);

   point_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] fill_ff, fill_in;
   logic                   do_push, do_pop;

   function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end else begin
         return p + 1'b1;
      end
   endfunction

   assign push_ready = (fill_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10: begin
            fill_in = fill_ff + 1'b1;
         end
         2'b01: begin
            fill_in = fill_ff - 1'b1;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/mbc_iter.sv */
`timescale 1ns / 1ps
module mbc_iter import mbc_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  point_type          pop_data,
   input  logic [COUNT_W-1:0] limit,
   output logic               esc_valid,
   input  logic               esc_ready,
   output escape_type         esc_data
);

   localparam int          TSH     = 2 * FRAC_BITS + 2;
   localparam logic [63:0] ESC_THR = (TSH < 64) ? (64'd1 << TSH) : '1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   fix_type            cr_ff, cr_in, ci_ff, ci_in;
   fix_type            x_ff, x_in, y_ff, y_in;
   logic signed [63:0] xx_ff, xx_in, yy_ff, yy_in, xy_ff, xy_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic               inside_ff, inside_in;
   logic [63:0]        mag;
   fix_type            x_next, y_next;

   assign mag    = xx_ff + yy_ff;
   assign x_next = sat_fix(((xx_ff - yy_ff) >>> FRAC_BITS) + 64'(cr_ff));
   assign y_next = sat_fix((xy_ff >>> (FRAC_BITS - 1)) + 64'(ci_ff));

   always_comb begin
      state_in  = state_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      xx_in     = xx_ff;
      yy_in     = yy_ff;
      xy_in     = xy_ff;
      n_in      = n_ff;
      inside_in = inside_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cr_in    = pop_data.cr;
               ci_in    = pop_data.ci;
               x_in     = '0;
               y_in     = '0;
               n_in     = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (n_ff >= limit) begin
               inside_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               xx_in    = x_ff * x_ff;
               yy_in    = y_ff * y_ff;
               xy_in    = x_ff * y_ff;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (mag > ESC_THR) begin
               inside_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               x_in     = x_next;
               y_in     = y_next;
               n_in     = n_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (esc_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pop_ready       = (state_ff == ST_IDLE);
   assign esc_valid       = (state_ff == ST_DONE);
   assign esc_data.count  = n_ff;
   assign esc_data.in_set = inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      xx_ff     <= xx_in;
      yy_ff     <= yy_in;
      xy_ff     <= xy_in;
      n_ff      <= n_in;
      inside_ff <= inside_in;
   end

endmodule

/* rtl/core/mbc_color.sv */
`timescale 1ns / 1ps
module mbc_color import mbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               esc_valid,
   output logic               esc_ready,
   input  escape_type         esc_data,
   input  logic [COUNT_W-1:0] limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CHAN_W-1:0]  rsp_red,
   output logic [CHAN_W-1:0]  rsp_green,
   output logic [CHAN_W-1:0]  rsp_blue,
   output logic [COUNT_W-1:0] rsp_iteration_count,
   output logic               rsp_inside_set
);

   localparam int SPAN_W = COUNT_W - 2;
   localparam int NUM_W  = SPAN_W + CHAN_W;
   localparam int WIDE_W = COUNT_W + CHAN_W;
   localparam int BIT_W  = $clog2(CHAN_W);

   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_SEG  = 2'd1;
   localparam logic [1:0] C_DIV  = 2'd2;
   localparam logic [1:0] C_FIN  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               inside_ff, inside_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [SEG_W-1:0]   seg_ff, seg_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   chan_type           quot_ff, quot_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   chan_type           red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_inside_ff, rsp_inside_in;

   logic [SPAN_W-1:0]  span_raw, span_new;
   logic [NUM_W-1:0]   trial;
   logic [WIDE_W-1:0]  rem_wide, rem_scaled;
   logic [SEG_W-1:0]   seg_nx;
   logic               slot_free;
   logic               frac_nz;

   assign span_raw   = limit[COUNT_W-1:2];
   assign span_new   = (span_raw == '0) ? SPAN_W'(1) : span_raw;
   assign trial      = NUM_W'(span_ff) << bit_ff;
   assign rem_wide   = {{CHAN_W{1'b0}}, rem_ff};
   assign rem_scaled = (rem_wide << CHAN_W) - rem_wide;
   assign seg_nx     = seg_ff + 1'b1;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign frac_nz    = (num_ff != '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      inside_in     = inside_ff;
      rem_in        = rem_ff;
      span_in       = span_ff;
      seg_in        = seg_ff;
      num_in        = num_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;
      case (state_ff)
         C_IDLE: begin
            if (esc_valid) begin
               count_in  = esc_data.count;
               inside_in = esc_data.in_set;
               rem_in    = esc_data.count;
               span_in   = span_new;
               seg_in    = '0;
               state_in  = C_SEG;
            end
         end
         C_SEG: begin
            if (seg_ff != SEG_LAST && rem_ff >= COUNT_W'(span_ff)) begin
               rem_in = rem_ff - COUNT_W'(span_ff);
               seg_in = seg_nx;
            end else begin
               num_in   = (seg_ff == SEG_LAST) ? '0 : rem_scaled[NUM_W-1:0];
               quot_in  = '0;
               bit_in   = BIT_W'(CHAN_W - 1);
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            if (num_ff >= trial) begin
               num_in  = num_ff - trial;
               quot_in = quot_ff | (CHAN_W'(1) << bit_ff);
            end
            if (bit_ff == '0) begin
               state_in = C_FIN;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         C_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               red_in        = mix_chan(PAL_RED[seg_ff], PAL_RED[seg_nx], quot_ff, frac_nz);
               green_in      = mix_chan(PAL_GREEN[seg_ff], PAL_GREEN[seg_nx], quot_ff,
                                        frac_nz);
               blue_in       = mix_chan(PAL_BLUE[seg_ff], PAL_BLUE[seg_nx], quot_ff, frac_nz);
               rsp_count_in  = count_ff;
               rsp_inside_in = inside_ff;
               state_in      = C_IDLE;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   assign esc_ready           = (state_ff == C_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_red             = red_ff;
   assign rsp_green           = green_ff;
   assign rsp_blue            = blue_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_inside_set      = rsp_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      inside_ff     <= inside_in;
      rem_ff        <= rem_in;
      span_ff       <= span_in;
      seg_ff        <= seg_in;
      num_ff        <= num_in;
      quot_ff       <= quot_in;
      bit_ff        <= bit_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
   end

endmodule

/* rtl/core/mandelbrot_escape_colorizer_unit.sv */
`timescale 1ns / 1ps
// Mandelbrot escape-time pixel colorizer. Each request carries a pixel column and row; the
// front stage forms the point c in signed fixed point (FRAC_BITS fraction bits, Q4.28 by
// default) and parks it in a two-entry queue. The iteration unit runs z = z^2 + c with three
// 32x32 multipliers, alternating a multiply state and an update state for each iteration
// up to the iteration limit (256 by default), and it takes one pixel at a time; for pixels
// with many iterations this loop sets the throughput. The color stage works on the
// previous pixel meanwhile (a segment search, then a bit-serial divider), and the response
// register lets the next requests enter while a result waits. Registers must be written
// only while the block is idle; the block itself does not enforce this.
module mandelbrot_escape_colorizer_unit import mbc_pkg::*; #(
   parameter int FRAC_BITS = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COORD_W-1:0]   req_col,
   input  logic [COORD_W-1:0]   req_row,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_W-1:0]    rsp_red,
   output logic [CHAN_W-1:0]    rsp_green,
   output logic [CHAN_W-1:0]    rsp_blue,
   output logic [COUNT_W-1:0]   rsp_iteration_count,
   output logic                 rsp_inside_set,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   fix_type            origin_re_ff, origin_re_in;
   fix_type            origin_im_ff, origin_im_in;
   logic [STEP_W-1:0]  step_re_ff, step_re_in;
   logic [STEP_W-1:0]  step_im_ff, step_im_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;

   logic       push_valid, push_ready;
   point_type  push_data;
   logic       pop_valid, pop_ready;
   point_type  pop_data;
   logic       esc_valid, esc_ready;
   escape_type esc_data;

   always_comb begin
      origin_re_in = origin_re_ff;
      origin_im_in = origin_im_ff;
      step_re_in   = step_re_ff;
      step_im_in   = step_im_ff;
      limit_in     = limit_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ORIGIN_RE: begin
               origin_re_in = csr_data[FIX_W-1:0];
            end
            CSR_ORIGIN_IM: begin
               origin_im_in = csr_data[FIX_W-1:0];
            end
            CSR_STEP_RE: begin
               step_re_in = csr_data[STEP_W-1:0];
            end
            CSR_STEP_IM: begin
               step_im_in = csr_data[STEP_W-1:0];
            end
            CSR_MAX_ITERATIONS: begin
               limit_in = csr_data[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= 32'hE000_0000;
         origin_im_ff <= 32'h1000_0000;
         step_re_ff   <= 31'd786432;
         step_im_ff   <= 31'd524288;
         limit_ff     <= 16'd256;
      end else begin
         origin_re_ff <= origin_re_in;
         origin_im_ff <= origin_im_in;
         step_re_ff   <= step_re_in;
         step_im_ff   <= step_im_in;
         limit_ff     <= limit_in;
      end
   end

   mbc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_col    (req_col),
      .req_row    (req_row),
      .origin_re  (origin_re_ff),
      .origin_im  (origin_im_ff),
      .step_re    (step_re_ff),
      .step_im    (step_im_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mbc_iter #(
      .FRAC_BITS (FRAC_BITS)
   ) u_iter (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .limit     (limit_ff),
      .esc_valid (esc_valid),
      .esc_ready (esc_ready),
      .esc_data  (esc_data)
   );

   mbc_color u_color (
      .clock               (clock),
      .reset               (reset),
      .esc_valid           (esc_valid),
      .esc_ready           (esc_ready),
      .esc_data            (esc_data),
      .limit               (limit_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_inside_set      (rsp_inside_set)
   );

endmodule

/* rtl/core/mbc_checker.sv */
`timescale 1ns / 1ps
module mbc_checker import mbc_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [CHAN_W-1:0]  rsp_red,
   input logic [CHAN_W-1:0]  rsp_green,
   input logic [CHAN_W-1:0]  rsp_blue,
   input logic [COUNT_W-1:0] rsp_iteration_count,
   input logic               rsp_inside_set
);

   logic [CHAN_W:0] gb_sum;

   assign gb_sum = {1'b0, rsp_green} + {1'b0, rsp_blue};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_red) && $stable(rsp_green) &&
      $stable(rsp_blue) && $stable(rsp_iteration_count) && $stable(rsp_inside_set))
      else $error("response changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // blue only appears on the blue-to-green segment, where green and blue sum to 255 or 254
   a_blue_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blue != '0 |->
      rsp_red == '0 && (gb_sum == 9'd255 || gb_sum == 9'd254))
      else $error("blue channel outside first color segment");

endmodule

bind mandelbrot_escape_colorizer_unit mbc_checker u_checker (.*);
